// ===== design/asgr_pkg.sv =====
// Package for the ANSI SGR stream filter: sizes, attribute and handshake structs,
// palette lookup and SGR code decoding.
// Depends on nothing; used by every module of the block.
package asgr_pkg;

	localparam int MAX_SEQ = 32;
	localparam int CNT_W = 6;
	localparam int PTR_W = $clog2(MAX_SEQ);
	localparam int BUF_DEPTH = 1 << PTR_W;

	localparam logic [7:0] CH_ESC = 8'h1B;
	localparam logic [7:0] CH_BEL = 8'h07;
	localparam logic [23:0] FG_RESET = 24'hFFFFFF;

	typedef logic [PTR_W-1:0] ptr_t;

	typedef struct packed {
		logic        bold;
		logic [23:0] fg;
		logic [23:0] bg;
		logic        bg_valid;
	} attr_t;

	typedef struct packed {
		logic sel_replay;
		logic fresh_step;
		logic rd_issue;
		logic rep_step;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic emit;
		logic bad;
		logic rep_end;
		logic pend_valid;
		logic out_free;
	} status_t;

	function automatic logic [23:0] palette(input logic bright, input logic [2:0] idx);
		logic [23:0] c;
		case ({bright, idx})
			4'd0: c = 24'h000000;
			4'd1: c = 24'hCD0000;
			4'd2: c = 24'h00CD00;
			4'd3: c = 24'hCDCD00;
			4'd4: c = 24'h0000EE;
			4'd5: c = 24'hCD00CD;
			4'd6: c = 24'h00CDCD;
			4'd7: c = 24'hE5E5E5;
			4'd8: c = 24'h7F7F7F;
			4'd9: c = 24'hFF0000;
			4'd10: c = 24'h00FF00;
			4'd11: c = 24'hFFFF00;
			4'd12: c = 24'h5C5CFF;
			4'd13: c = 24'hFF00FF;
			4'd14: c = 24'h00FFFF;
			default: c = 24'hFFFFFF;
		endcase
		return c;
	endfunction

	function automatic attr_t attr_default(input logic [23:0] dflt);
		attr_t a;
		a.bold = 1'b0;
		a.fg = dflt;
		a.bg = 24'h0;
		a.bg_valid = 1'b0;
		return a;
	endfunction

	function automatic attr_t apply_code(input attr_t a, input logic [7:0] c,
		input logic [23:0] dflt);
		attr_t r;
		logic [7:0] d30;
		logic [7:0] d90;
		logic [7:0] d40;
		logic [7:0] d100;
		r = a;
		d30 = c - 8'd30;
		d90 = c - 8'd90;
		d40 = c - 8'd40;
		d100 = c - 8'd100;
		if (c == 8'd0) begin
			r = attr_default(dflt);
		end else if (c == 8'd1) begin
			r.bold = 1'b1;
		end else if (c == 8'd22) begin
			r.bold = 1'b0;
		end else if (c >= 8'd30 && c <= 8'd37) begin
			r.fg = palette(1'b0, d30[2:0]);
		end else if (c >= 8'd90 && c <= 8'd97) begin
			r.fg = palette(1'b1, d90[2:0]);
		end else if (c >= 8'd40 && c <= 8'd47) begin
			r.bg = palette(1'b0, d40[2:0]);
			r.bg_valid = 1'b1;
		end else if (c >= 8'd100 && c <= 8'd107) begin
			r.bg = palette(1'b1, d100[2:0]);
			r.bg_valid = 1'b1;
		end else if (c == 8'd39) begin
			r.fg = dflt;
		end else if (c == 8'd49) begin
			r.bg = 24'h0;
			r.bg_valid = 1'b0;
		end
		return r;
	endfunction

endpackage

// ===== design/asgr_ctrl.sv =====
// Controller of the ANSI SGR stream filter: sequences fresh bytes, replay of
// held bytes from the sequence buffer and the final flush of a replay run.
// Depends on asgr_pkg.
module asgr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  asgr_pkg::status_t st,
	output asgr_pkg::cmd_t    cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD,
		S_EX,
		S_FLUSH
	} state_t;

	state_t state_q;
	state_t state_nx;

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				in_ready = st.out_free;
				cmd.fresh_step = in_valid && st.out_free;
				if (cmd.fresh_step && st.bad) begin
					state_nx = S_RD;
				end
			end
			S_RD: begin
				cmd.rd_issue = 1'b1;
				state_nx = S_EX;
			end
			S_EX: begin
				cmd.sel_replay = 1'b1;
				if (!(st.emit && st.pend_valid && !st.out_free)) begin
					cmd.rep_step = 1'b1;
					if (st.bad) begin
						state_nx = S_RD;
					end else if (st.rep_end) begin
						state_nx = (st.pend_valid || st.emit) ? S_FLUSH : S_IDLE;
					end else begin
						state_nx = S_RD;
					end
				end
			end
			S_FLUSH: begin
				if (st.out_free) begin
					cmd.flush = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

// ===== design/asgr_dp.sv =====
// Datapath of the ANSI SGR stream filter: escape parser state, attribute
// registers, circular sequence buffer, pending result and output register.
// Depends on asgr_pkg.
module asgr_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  asgr_pkg::cmd_t     cmd,
	output asgr_pkg::status_t  st,
	input  logic [23:0]       default_fg,
	input  logic [7:0]        in_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_char,
	output logic              is_bold,
	output logic [23:0]       fg_rgb,
	output logic [23:0]       bg_rgb,
	output logic              bg_set,
	output logic              last
);

	typedef enum logic [2:0] {
		M_GROUND,
		M_ESC,
		M_CSI,
		M_OSC,
		M_OSC_ST,
		M_CHARSET
	} mode_t;

	mode_t                            mode_q;
	logic [asgr_pkg::CNT_W-1:0]       cnt_q;
	logic [7:0]                       acc_q;
	logic                             seen_q;
	logic                             anyp_q;
	logic                             quest_q;
	asgr_pkg::attr_t                  cur_q;
	asgr_pkg::attr_t                  sh_q;
	asgr_pkg::ptr_t                   base_q;
	asgr_pkg::ptr_t                   end_q;
	asgr_pkg::ptr_t                   rd_ptr_q;
	logic [7:0]                       rd_data_q;
	logic [7:0]                       mem_q [asgr_pkg::BUF_DEPTH];
	logic                             pend_valid_q;
	logic [7:0]                       pend_char_q;
	asgr_pkg::attr_t                  pend_attr_q;
	logic                             out_valid_q;
	logic [7:0]                       out_char_q;
	asgr_pkg::attr_t                  out_attr_q;
	logic                             out_last_q;

	logic [7:0]                 b;
	mode_t                      mode_nx;
	logic [asgr_pkg::CNT_W-1:0] cnt_nx;
	logic [7:0]                 acc_nx;
	logic                       seen_nx;
	logic                       anyp_nx;
	logic                       quest_nx;
	asgr_pkg::attr_t            cur_nx;
	asgr_pkg::attr_t            sh_nx;
	asgr_pkg::attr_t            sh_fin;
	logic                       emit;
	logic                       bad;
	logic                       hold;
	logic                       esc_start;
	logic                       hold_ok;
	logic                       is_digit;
	logic                       is_letter;
	logic [11:0]                acc_wide;
	logic                       step;
	logic                       out_free;
	asgr_pkg::ptr_t             wr_ptr;

	assign b = cmd.sel_replay ? rd_data_q : in_byte;
	assign hold_ok = cnt_q < asgr_pkg::CNT_W'(asgr_pkg::MAX_SEQ - 1);
	assign is_digit = (b >= "0") && (b <= "9");
	assign is_letter = ((b >= "A") && (b <= "Z")) || ((b >= "a") && (b <= "z"));
	assign acc_wide = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {8'h00, b[3:0]};
	assign step = cmd.fresh_step || cmd.rep_step;
	assign out_free = !out_valid_q || out_ready;
	assign wr_ptr = base_q + asgr_pkg::PTR_W'(cnt_q);

	always_comb begin
		mode_nx = mode_q;
		cnt_nx = cnt_q;
		acc_nx = acc_q;
		seen_nx = seen_q;
		anyp_nx = anyp_q;
		quest_nx = quest_q;
		cur_nx = cur_q;
		sh_nx = sh_q;
		sh_fin = sh_q;
		emit = 1'b0;
		bad = 1'b0;
		hold = 1'b0;
		esc_start = 1'b0;
		case (mode_q)
			M_ESC: begin
				if (b == "[") begin
					if (!hold_ok) begin
						bad = 1'b1;
					end else begin
						hold = 1'b1;
						mode_nx = M_CSI;
						sh_nx = cur_q;
						acc_nx = 8'h00;
						seen_nx = 1'b0;
						anyp_nx = 1'b0;
						quest_nx = 1'b0;
					end
				end else if (b == "]") begin
					if (!hold_ok) begin
						bad = 1'b1;
					end else begin
						hold = 1'b1;
						mode_nx = M_OSC;
					end
				end else if (b == "(" || b == ")") begin
					if (!hold_ok) begin
						bad = 1'b1;
					end else begin
						hold = 1'b1;
						mode_nx = M_CHARSET;
					end
				end else if (b == "=" || b == ">") begin
					mode_nx = M_GROUND;
					cnt_nx = '0;
				end else begin
					bad = 1'b1;
				end
			end
			M_CSI: begin
				if (is_digit || b == ";" || b == "?") begin
					if (!hold_ok) begin
						bad = 1'b1;
					end else begin
						hold = 1'b1;
						anyp_nx = 1'b1;
						if (b == ";" || b == "?") begin
							if (b == "?") begin
								quest_nx = 1'b1;
							end
							if (seen_q) begin
								sh_nx = asgr_pkg::apply_code(sh_q, acc_q, default_fg);
							end
							acc_nx = 8'h00;
							seen_nx = 1'b0;
						end else begin
							acc_nx = (acc_wide > 12'd255) ? 8'hFF : acc_wide[7:0];
							seen_nx = 1'b1;
						end
					end
				end else if (b == "m") begin
					if (quest_q) begin
						bad = 1'b1;
					end else begin
						if (seen_q) begin
							sh_fin = asgr_pkg::apply_code(sh_q, acc_q, default_fg);
						end
						if (!anyp_q) begin
							sh_fin = asgr_pkg::attr_default(default_fg);
						end
						sh_nx = sh_fin;
						cur_nx = sh_fin;
						acc_nx = 8'h00;
						seen_nx = 1'b0;
						mode_nx = M_GROUND;
						cnt_nx = '0;
					end
				end else if (is_letter) begin
					mode_nx = M_GROUND;
					cnt_nx = '0;
				end else begin
					bad = 1'b1;
				end
			end
			M_OSC: begin
				if (b == asgr_pkg::CH_BEL) begin
					mode_nx = M_GROUND;
					cnt_nx = '0;
				end else if (!hold_ok) begin
					bad = 1'b1;
				end else begin
					hold = 1'b1;
					if (b == asgr_pkg::CH_ESC) begin
						mode_nx = M_OSC_ST;
					end
				end
			end
			M_OSC_ST: begin
				if (b == "\\") begin
					mode_nx = M_GROUND;
					cnt_nx = '0;
				end else begin
					bad = 1'b1;
				end
			end
			M_CHARSET: begin
				if (is_letter || is_digit) begin
					mode_nx = M_GROUND;
					cnt_nx = '0;
				end else begin
					bad = 1'b1;
				end
			end
			default: begin
				mode_nx = M_GROUND;
				if (b == asgr_pkg::CH_ESC) begin
					esc_start = 1'b1;
					mode_nx = M_ESC;
					cnt_nx = asgr_pkg::CNT_W'(1);
				end else if (b <= 8'h08 || b == 8'h0B || b == 8'h0C ||
					(b >= 8'h0E && b <= 8'h1F)) begin
					emit = 1'b0;
				end else begin
					emit = 1'b1;
				end
			end
		endcase
		if (hold) begin
			cnt_nx = cnt_q + asgr_pkg::CNT_W'(1);
		end
		if (bad) begin
			mode_nx = M_GROUND;
			cnt_nx = '0;
		end
	end

	assign st.emit = emit;
	assign st.bad = bad;
	assign st.rep_end = (rd_ptr_q == end_q);
	assign st.pend_valid = pend_valid_q;
	assign st.out_free = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_GROUND;
			cnt_q <= '0;
			acc_q <= 8'h00;
			seen_q <= 1'b0;
			anyp_q <= 1'b0;
			quest_q <= 1'b0;
			cur_q <= asgr_pkg::attr_default(asgr_pkg::FG_RESET);
			sh_q <= '0;
			base_q <= '0;
			end_q <= '0;
			rd_ptr_q <= '0;
		end else if (step) begin
			mode_q <= mode_nx;
			cnt_q <= cnt_nx;
			acc_q <= acc_nx;
			seen_q <= seen_nx;
			anyp_q <= anyp_nx;
			quest_q <= quest_nx;
			cur_q <= cur_nx;
			sh_q <= sh_nx;
			if (cmd.rep_step) begin
				if (esc_start) begin
					base_q <= rd_ptr_q;
				end
				rd_ptr_q <= bad ? (base_q + asgr_pkg::PTR_W'(1)) :
					(rd_ptr_q + asgr_pkg::PTR_W'(1));
			end else if (bad) begin
				rd_ptr_q <= base_q + asgr_pkg::PTR_W'(1);
				end_q <= wr_ptr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fresh_step && (hold || bad || esc_start)) begin
			mem_q[wr_ptr] <= b;
		end
		if (cmd.rd_issue) begin
			rd_data_q <= mem_q[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (cmd.fresh_step && emit) begin
				out_valid_q <= 1'b1;
			end else if (cmd.rep_step && emit && pend_valid_q) begin
				out_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.rep_step && emit) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fresh_step && emit) begin
			out_char_q <= b;
			out_attr_q <= cur_q;
			out_last_q <= 1'b1;
		end else if ((cmd.rep_step && emit && pend_valid_q) || cmd.flush) begin
			out_char_q <= pend_char_q;
			out_attr_q <= pend_attr_q;
			out_last_q <= cmd.flush;
		end
		if (cmd.rep_step && emit) begin
			pend_char_q <= b;
			pend_attr_q <= cur_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char = out_char_q;
	assign is_bold = out_attr_q.bold;
	assign fg_rgb = out_attr_q.fg;
	assign bg_rgb = out_attr_q.bg_valid ? out_attr_q.bg : 24'h0;
	assign bg_set = out_attr_q.bg_valid;
	assign last = out_last_q;

endmodule

// ===== design/ansi_sgr_stream_filter_unit.sv =====
// Top level of the ANSI SGR stream filter: one byte of text becomes its result in the cycle
// after acceptance, and a new byte is accepted in every cycle the output register is free
// while no replay run is active. A malformed or overlong escape sequence replays its held
// bytes one at a time via a registered sequence buffer read, then flushes the last result.
// Asynchronous active-low reset returns to ground text mode with default attributes;
// the sequence buffer is not cleared and needs no clearing pass.
module ansi_sgr_stream_filter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_char,
	output logic        is_bold,
	output logic [23:0] fg_rgb,
	output logic [23:0] bg_rgb,
	output logic        bg_set,
	output logic        last
);

	logic [23:0]       default_fg_q;
	asgr_pkg::cmd_t    cmd;
	asgr_pkg::status_t st;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {8'h00, default_fg_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_fg_q <= asgr_pkg::FG_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
			default_fg_q <= pwdata[23:0];
		end
	end

	asgr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	asgr_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.default_fg (default_fg_q),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_char   (out_char),
		.is_bold    (is_bold),
		.fg_rgb     (fg_rgb),
		.bg_rgb     (bg_rgb),
		.bg_set     (bg_set),
		.last       (last)
	);

`ifndef SYNTHESIS
	a_ready_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!out_valid || out_ready))
		else $error("input taken while the output register is blocked");

	a_flush_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> (out_valid && last))
		else $error("flushed result not marked as last");

	a_no_step_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.fresh_step && (cmd.rep_step || cmd.rd_issue || cmd.flush)))
		else $error("fresh byte accepted during a replay run");

	a_bg_masked: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !bg_set) |-> (bg_rgb == 24'h0))
		else $error("background color shown without a background");
`endif

endmodule

// ===== tb/ansi_sgr_stream_filter_checker.sv =====
// Checker for the ANSI SGR stream filter: watches the byte, result and register channels,
// predicts every result from its own copy of the parser state and compares field by field.
// Depends on asgr_pkg for the buffer size, the control byte codes and the reset foreground.
`timescale 1ns / 100ps
module ansi_sgr_stream_filter_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  out_char,
	input  logic        is_bold,
	input  logic [23:0] fg_rgb,
	input  logic [23:0] bg_rgb,
	input  logic        bg_set,
	input  logic        last,
	output int          fail_count,
	output int          pending
);

	typedef enum logic [2:0] {
		PM_GROUND, PM_ESC, PM_CSI, PM_OSC, PM_OSC_ST, PM_CHARSET
	} pmode_t;

	localparam int FG_REG_ADDR = 0;
	localparam int RESULT_CAP = 34;
	localparam int STACK_DEPTH = asgr_pkg::MAX_SEQ + 4;

	typedef struct {
		logic [7:0]  ch;
		logic        bold;
		logic [23:0] fg;
		logic [23:0] bg;
		logic        bg_on;
		logic        fin;
	} glyph_t;

	glyph_t glyph_q[$];

	logic [23:0] dflt_fg;
	pmode_t      pmode;
	logic [7:0]  held [asgr_pkg::MAX_SEQ];
	int          held_n;
	int          num_acc;
	logic        num_seen, any_param, saw_q;
	logic        a_bold, a_bg_on, s_bold, s_bg_on;
	logic [23:0] a_fg, a_bg, s_fg, s_bg;

	function automatic logic [23:0] color_of(input logic bright, input int idx);
		logic [23:0] dark [8];
		logic [23:0] lit [8];
		dark = '{24'h000000, 24'hCD0000, 24'h00CD00, 24'hCDCD00,
			24'h0000EE, 24'hCD00CD, 24'h00CDCD, 24'hE5E5E5};
		lit = '{24'h7F7F7F, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
			24'h5C5CFF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF};
		return bright ? lit[idx] : dark[idx];
	endfunction

	task automatic shadow_to_default();
		s_bold = 1'b0;
		s_fg = dflt_fg;
		s_bg = 24'h0;
		s_bg_on = 1'b0;
	endtask

	task automatic take_code(input int c);
		if (c == 0) begin
			shadow_to_default();
		end else if (c == 1) begin
			s_bold = 1'b1;
		end else if (c == 22) begin
			s_bold = 1'b0;
		end else if (c >= 30 && c <= 37) begin
			s_fg = color_of(1'b0, c - 30);
		end else if (c >= 90 && c <= 97) begin
			s_fg = color_of(1'b1, c - 90);
		end else if (c >= 40 && c <= 47) begin
			s_bg = color_of(1'b0, c - 40);
			s_bg_on = 1'b1;
		end else if (c >= 100 && c <= 107) begin
			s_bg = color_of(1'b1, c - 100);
			s_bg_on = 1'b1;
		end else if (c == 39) begin
			s_fg = dflt_fg;
		end else if (c == 49) begin
			s_bg = 24'h0;
			s_bg_on = 1'b0;
		end
	endtask

	task automatic close_param();
		if (num_seen) begin
			take_code(num_acc);
		end
		num_acc = 0;
		num_seen = 1'b0;
	endtask

	function automatic logic keep(input logic [7:0] b);
		if (held_n >= asgr_pkg::MAX_SEQ - 1) begin
			return 1'b0;
		end
		held[held_n] = b;
		held_n++;
		return 1'b1;
	endfunction

	function automatic logic alpha(input logic [7:0] b);
		return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
	endfunction

	task automatic parse_byte(input logic [7:0] first);
		logic [7:0] stk [STACK_DEPTH];
		int sp;
		int made;
		logic [7:0] b;
		logic bad;
		glyph_t g;
		sp = 1;
		made = 0;
		stk[0] = first;
		while (sp > 0) begin
			sp--;
			b = stk[sp];
			bad = 1'b0;
			case (pmode)
				PM_ESC: begin
					if (b == "[") begin
						if (!keep(b)) begin
							bad = 1'b1;
						end else begin
							pmode = PM_CSI;
							s_bold = a_bold;
							s_fg = a_fg;
							s_bg = a_bg;
							s_bg_on = a_bg_on;
							num_acc = 0;
							num_seen = 1'b0;
							any_param = 1'b0;
							saw_q = 1'b0;
						end
					end else if (b == "]") begin
						if (!keep(b)) bad = 1'b1;
						else pmode = PM_OSC;
					end else if (b == "(" || b == ")") begin
						if (!keep(b)) bad = 1'b1;
						else pmode = PM_CHARSET;
					end else if (b == "=" || b == ">") begin
						pmode = PM_GROUND;
						held_n = 0;
					end else begin
						bad = 1'b1;
					end
				end
				PM_CSI: begin
					if ((b >= "0" && b <= "9") || b == ";" || b == "?") begin
						if (!keep(b)) begin
							bad = 1'b1;
						end else begin
							any_param = 1'b1;
							if (b == ";" || b == "?") begin
								if (b == "?") saw_q = 1'b1;
								close_param();
							end else begin
								num_acc = num_acc * 10 + (b - "0");
								if (num_acc > 255) num_acc = 255;
								num_seen = 1'b1;
							end
						end
					end else if (b == "m") begin
						if (saw_q) begin
							bad = 1'b1;
						end else begin
							close_param();
							if (!any_param) shadow_to_default();
							a_bold = s_bold;
							a_fg = s_fg;
							a_bg = s_bg;
							a_bg_on = s_bg_on;
							pmode = PM_GROUND;
							held_n = 0;
						end
					end else if (alpha(b)) begin
						pmode = PM_GROUND;
						held_n = 0;
					end else begin
						bad = 1'b1;
					end
				end
				PM_OSC: begin
					if (b == asgr_pkg::CH_BEL) begin
						pmode = PM_GROUND;
						held_n = 0;
					end else if (!keep(b)) begin
						bad = 1'b1;
					end else if (b == asgr_pkg::CH_ESC) begin
						pmode = PM_OSC_ST;
					end
				end
				PM_OSC_ST: begin
					if (b == "\\") begin
						pmode = PM_GROUND;
						held_n = 0;
					end else begin
						bad = 1'b1;
					end
				end
				PM_CHARSET: begin
					if (alpha(b) || (b >= "0" && b <= "9")) begin
						pmode = PM_GROUND;
						held_n = 0;
					end else begin
						bad = 1'b1;
					end
				end
				default: begin
					pmode = PM_GROUND;
					if (b == asgr_pkg::CH_ESC) begin
						held[0] = b;
						held_n = 1;
						pmode = PM_ESC;
					end else if (b <= 8'h08 || b == 8'h0B || b == 8'h0C ||
						(b >= 8'h0E && b <= 8'h1F)) begin
					end else if (made < RESULT_CAP) begin
						g.ch = b;
						g.bold = a_bold;
						g.fg = a_fg;
						g.bg = a_bg_on ? a_bg : 24'h0;
						g.bg_on = a_bg_on;
						g.fin = 1'b0;
						glyph_q.push_back(g);
						made++;
					end
				end
			endcase
			if (bad) begin
				pmode = PM_GROUND;
				if (sp < STACK_DEPTH) begin
					stk[sp] = b;
					sp++;
				end
				for (int i = held_n; i > 1; i--) begin
					if (sp < STACK_DEPTH) begin
						stk[sp] = held[i-1];
						sp++;
					end
				end
				held_n = 0;
			end
		end
		if (made > 0) begin
			glyph_q[glyph_q.size()-1].fin = 1'b1;
		end
	endtask

	assign pending = glyph_q.size();

	always @(posedge clk or negedge arst_n) begin
		glyph_t e;
		if (!arst_n) begin
			glyph_q.delete();
			fail_count = 0;
			dflt_fg = asgr_pkg::FG_RESET;
			pmode = PM_GROUND;
			held_n = 0;
			num_acc = 0;
			num_seen = 1'b0;
			any_param = 1'b0;
			saw_q = 1'b0;
			a_bold = 1'b0;
			a_fg = asgr_pkg::FG_RESET;
			a_bg = 24'h0;
			a_bg_on = 1'b0;
			s_bold = 1'b0;
			s_fg = 24'h0;
			s_bg = 24'h0;
			s_bg_on = 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (glyph_q.size() == 0) begin
					$display("%0t: unexpected result char %h", $time, out_char);
					fail_count++;
				end else begin
					e = glyph_q.pop_front();
					if (e.ch !== out_char || e.bold !== is_bold || e.fg !== fg_rgb ||
						e.bg !== bg_rgb || e.bg_on !== bg_set || e.fin !== last) begin
						$display("%0t: expected ch %h bold %b fg %h bg %h bg_set %b last %b",
							$time, e.ch, e.bold, e.fg, e.bg, e.bg_on, e.fin);
						$display("%0t: actual   ch %h bold %b fg %h bg %h bg_set %b last %b",
							$time, out_char, is_bold, fg_rgb, bg_rgb, bg_set, last);
						fail_count++;
					end
				end
			end
			if (psel && penable && pwrite && pready && paddr[2] == FG_REG_ADDR[0]) begin
				dflt_fg = pwdata[23:0];
			end
			if (in_valid && in_ready) begin
				parse_byte(in_byte);
			end
		end
	end

endmodule

// ===== tb/ansi_sgr_stream_filter_unit_test.sv =====
// Testbench top for the ANSI SGR stream filter: clock, reset, byte stimulus, register
// writes and the verdict. Depends on ansi_sgr_stream_filter_unit and the checker module.
`timescale 1ns / 100ps
module ansi_sgr_stream_filter_unit_test;

	localparam logic [2:0] FG_REG_ADDR = 3'd0;
	localparam int DRAIN_CYCLES = 120;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_char;
	logic        is_bold;
	logic [23:0] fg_rgb;
	logic [23:0] bg_rgb;
	logic        bg_set;
	logic        last;
	int          fail_count;
	int          pending;
	logic        gaps_on = 1'b1;
	int          sent = 0;

	ansi_sgr_stream_filter_unit u_top (.*);
	ansi_sgr_stream_filter_checker u_check (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= !(gaps_on && $urandom_range(99) < 16);
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	task automatic push(input logic [7:0] b);
		if (gaps_on && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		forever begin
			@(negedge clk);
			if (in_ready) break;
		end
		@(posedge clk);
		sent++;
	endtask

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++) push(s[i]);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_fg(input logic [23:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= FG_REG_ADDR;
		pwdata <= {8'h0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	function automatic string sgr_params();
		int codes [14] = '{0, 1, 22, 30, 37, 39, 40, 47, 49, 90, 97, 100, 107, 5};
		string s;
		int n;
		s = "";
		n = $urandom_range(0, 4);
		for (int i = 0; i < n; i++) begin
			if (i > 0) s = {s, ";"};
			case ($urandom_range(0, 5))
				0: s = s;
				1: s = {s, $sformatf("%0d", $urandom_range(0, 999))};
				default: s = {s, $sformatf("%0d", codes[$urandom_range(0, 13)])};
			endcase
		end
		return s;
	endfunction

	task automatic random_seq();
		string s;
		int n;
		string finals;
		string opens;
		string sets;
		string keys;
		finals = "ABHJKm";
		opens = "()";
		sets = "B0A.!";
		keys = "=>x";
		case ($urandom_range(0, 11))
			0, 1, 2: push_str({"\033[", sgr_params(), "m"});
			3: push_str({"\033[", sgr_params(), "?", sgr_params(),
				($urandom_range(1) ? "m" : "h")});
			4: begin
				push_str({"\033[", sgr_params()});
				push(finals[$urandom_range(0, 5)]);
			end
			5: begin
				s = "\033]";
				n = $urandom_range(0, 8) == 0 ? 40 : $urandom_range(0, 10);
				for (int i = 0; i < n; i++) s = {s, 8'($urandom_range(32, 126))};
				case ($urandom_range(0, 2))
					0: s = {s, "\007"};
					1: s = {s, "\033\\"};
					default: s = {s, "\033x"};
				endcase
				push_str(s);
			end
			6: begin
				push_str("\033");
				push(opens[$urandom_range(0, 1)]);
				push(sets[$urandom_range(0, 4)]);
			end
			7: begin
				push_str("\033");
				push(keys[$urandom_range(0, 2)]);
			end
			8: begin
				s = "\033[";
				for (int i = 0; i < 34; i++) s = {s, ($urandom_range(1) ? "1" : ";")};
				push_str({s, "m"});
			end
			9: push(8'($urandom_range(0, 255)));
			default: begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++) push(8'($urandom_range(32, 126)));
			end
		endcase
	endtask

	initial begin
		logic [23:0] fg_set [3];
		fg_set = '{24'h000000, 24'hFFFFFF, 24'h0};
		fg_set[2] = 24'($urandom);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		push_str("A~\000\377\t\n\r\177\033[m");
		push_str("x\033[1;31;44mB\033[;;22;39;49mC\033[97;107;300mD\033[90;100;0mE");
		push_str("\033[?25h\033[?1mF\033]t\007\033]u\033\\\033]v\033qG");
		push_str("\033(B\033)0\033=\033>\033xH\033\033[5m");
		push_str("\033[1111111111111111111111111111111111m");
		settle();
		for (int p = 0; p < 3; p++) begin
			write_fg(fg_set[p]);
			push_str("\033[0mI\033[31;39mJ");
			while (sent < 90 * (p + 1) + 150) begin
				gaps_on <= !(p == 1 && sent > 250);
				random_seq();
			end
			gaps_on <= 1'b1;
			settle();
		end
		if (fail_count == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
